[hdl/lcdnw_pkg.sv]
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants for the character LCD nibble writer
// request/result payloads, decoded operations, sequencer phases, timing regs
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    // request opcodes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_CMDB  = 3'd1;
    localparam logic [2:0] CMD_DATAB = 3'd2;
    localparam logic [2:0] CMD_INIT  = 3'd3;
    localparam logic [2:0] CMD_GOTO  = 3'd4;

    // timing register indexes
    localparam logic [2:0] REG_SETUP      = 3'd0;
    localparam logic [2:0] REG_LEAD       = 3'd1;
    localparam logic [2:0] REG_HOLD       = 3'd2;
    localparam logic [2:0] REG_GAP        = 3'd3;
    localparam logic [2:0] REG_POWER_UP   = 3'd4;
    localparam logic [2:0] REG_WAKE_LONG  = 3'd5;
    localparam logic [2:0] REG_WAKE_SHORT = 3'd6;
    localparam logic [2:0] REG_SETTLE     = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // init progress marks
    localparam logic [3:0] STEP_NONE       = 4'd0;
    localparam logic [3:0] STEP_WAKE_FIRST = 4'd1;
    localparam logic [3:0] STEP_WAKE_LAST  = 4'd4;
    localparam logic [3:0] STEP_CMD_FIRST  = 4'd5;
    localparam logic [3:0] STEP_CMD_LAST   = 4'd8;

    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_value;
        logic       row;
        logic [5:0] column;
    } request_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       rejected;
    } result_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_TICK,
        K_BYTE,
        K_INIT
    } kind_t;

    // decoded operation handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic       select;
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_POWER,
        PH_WSETUP,
        PH_WLEAD,
        PH_WHOLD,
        PH_WAFTER,
        PH_BSETUP,
        PH_BLEAD1,
        PH_BHOLD1,
        PH_BGAP,
        PH_BLEAD2,
        PH_BHOLD2,
        PH_SETTLE
    } phase_t;

    typedef struct packed {
        logic [7:0]  setup_ticks;
        logic [7:0]  enable_lead_ticks;
        logic [7:0]  enable_hold_ticks;
        logic [7:0]  nibble_gap_ticks;
        logic [15:0] power_up_ticks;
        logic [15:0] wake_long_ticks;
        logic [15:0] wake_short_ticks;
        logic [15:0] settle_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        setup_ticks:       8'd10,
        enable_lead_ticks: 8'd5,
        enable_hold_ticks: 8'd10,
        nibble_gap_ticks:  8'd20,
        power_up_ticks:    16'd20000,
        wake_long_ticks:   16'd10000,
        wake_short_ticks:  16'd1000,
        settle_ticks:      16'd5000
    };

    typedef struct packed {
        logic       busy;
        logic [3:0] init_step;
    } status_t;

    // command bytes sent after the wake nibbles
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h2C;
            2'd1:    val = 8'h0C;
            2'd2:    val = 8'h01;
            default: val = 8'h02;
        endcase
        return val;
    endfunction

endpackage

[hdl/char_lcd_nibble_write_sequencer_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_core: 4-bit character LCD write sequencer
// decodes requests and ticks, drives RS / E / D4..D7 levels per transaction
// ----------------------------------------------------------------------------
// usage:
//   request side is a queue: a transaction completes when push is high and
//   full is low. each request is a tick (one microsecond), a command byte,
//   a data byte, init or goto. byte, init and goto requests start a sequence
//   only while idle; otherwise they come back with rejected set.
//   result side is a queue: while empty is low the oldest result sits on
//   result, and pop takes it. every request yields exactly one result holding
//   the pin levels after that request plus busy and rejected flags.
//   the timing registers are written over cfg_valid / cfg_ready / cfg_index /
//   cfg_data (ready is always high) and must only change while idle.
//   a request passes the registered decoupling and result queues before its
//   result shows; throughput is one transaction per cycle while the result
//   side is popped. if the result side stalls, two results and two decoded
//   requests buffer up before full rises. reset returns the sequencer to idle
//   with all pins low and the timing registers at their power-on values.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // request queue side
    input  logic                                    push,
    output logic                                    full,
    input  lcdnw_pkg::request_t                     request,
    // result queue side
    output logic                                    empty,
    input  logic                                    pop,
    output lcdnw_pkg::result_t                      result,
    // timing register writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lcdnw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lcdnw_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import lcdnw_pkg::*;

    cfg_t    cfg_reg;
    op_t     front_op;
    op_t     mid_op;
    logic    mid_empty, mid_pop;
    logic    res_full, res_push;
    result_t back_res;
    status_t status;

    // timing registers, write-only, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SETUP:      cfg_reg.setup_ticks       <= cfg_data[7:0];
                REG_LEAD:       cfg_reg.enable_lead_ticks <= cfg_data[7:0];
                REG_HOLD:       cfg_reg.enable_hold_ticks <= cfg_data[7:0];
                REG_GAP:        cfg_reg.nibble_gap_ticks  <= cfg_data[7:0];
                REG_POWER_UP:   cfg_reg.power_up_ticks    <= cfg_data;
                REG_WAKE_LONG:  cfg_reg.wake_long_ticks   <= cfg_data;
                REG_WAKE_SHORT: cfg_reg.wake_short_ticks  <= cfg_data;
                REG_SETTLE:     cfg_reg.settle_ticks      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: classify the request as it arrives
    lcdnw_front u_front (
        .request (request),
        .op      (front_op)
    );

    // decoupling queue between decoder and sequencer
    lcdnw_queue #(
        .item_t (op_t)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_op),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_op),
        .empty (mid_empty)
    );

    // back: one sequencer step per decoded transaction
    lcdnw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op       (mid_op),
        .op_valid (!mid_empty),
        .op_pop   (mid_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (back_res),
        .status   (status)
    );

    // result queue, lets the sequencer keep going while the reader stalls
    lcdnw_queue #(
        .item_t (result_t)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // a rejected request leaves the sequencer busy
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.rejected) |-> result.busy_res)
        else $error("rejected result without busy");

    // idle sequencer carries no init progress
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> (status.init_step == STEP_NONE))
        else $error("init step left over while idle");

    // init progress never runs past the last command byte
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.init_step <= STEP_CMD_LAST)
        else $error("init step out of range");

    // sequencer only steps when a result slot is free
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
        else $error("result pushed into full queue");

endmodule

[hdl/lcdnw_queue.sv]
// ----------------------------------------------------------------------------
// lcdnw_queue: two-entry first-in first-out buffer
// head slot is shown directly, second slot shifts forward on pop
// ----------------------------------------------------------------------------
module lcdnw_queue #(
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);
    logic [1:0] count_reg, count_next;
    item_t      head_reg;
    item_t      tail_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = head_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && count_reg == 2'd2)
        begin
            head_reg <= tail_reg;
        end
        if (do_push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && do_pop))
            begin
                head_reg <= wdata;
            end
            else
            begin
                tail_reg <= wdata;
            end
        end
    end

endmodule

[hdl/lcdnw_front.sv]
// ----------------------------------------------------------------------------
// lcdnw_front: request decoder
// sorts requests into tick, byte write, init or no-op and forms the goto byte
// ----------------------------------------------------------------------------
module lcdnw_front (
    input  lcdnw_pkg::request_t request,
    output lcdnw_pkg::op_t      op
);
    import lcdnw_pkg::*;

    always_comb
    begin
        op.kind       = K_NOP;
        op.byte_value = request.byte_value;
        op.select     = 1'b0;
        case (request.cmd)
            CMD_TICK:  op.kind = K_TICK;
            CMD_CMDB:  op.kind = K_BYTE;
            CMD_DATAB:
            begin
                op.kind   = K_BYTE;
                op.select = 1'b1;
            end
            CMD_INIT:  op.kind = K_INIT;
            CMD_GOTO:
            begin
                // 0x80 + column, plus 0x40 on row one
                op.kind       = K_BYTE;
                op.byte_value = {1'b1, request.row, request.column};
            end
            default:   op.kind = K_NOP;
        endcase
    end

endmodule

[hdl/lcdnw_back.sv]
// ----------------------------------------------------------------------------
// lcdnw_back: timed pin sequencer
// runs one decoded operation per cycle unless res_full, forms the pin-level result
// ----------------------------------------------------------------------------
module lcdnw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lcdnw_pkg::cfg_t     cfg,
    input  lcdnw_pkg::op_t      op,
    input  logic                op_valid,
    output logic                op_pop,
    input  logic                res_full,
    output logic                res_push,
    output lcdnw_pkg::result_t  res,
    output lcdnw_pkg::status_t  status
);
    import lcdnw_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  byte_reg, byte_next;
    logic [3:0]  step_reg, step_next;
    logic        rs_reg, rs_next;
    logic        en_reg, en_next;
    logic [3:0]  nib_reg, nib_next;
    logic        fire, idle, advance, rej;

    assign fire     = op_valid && !res_full;
    assign op_pop   = fire;
    assign res_push = fire;
    assign idle     = (phase_reg == PH_IDLE);

    assign status.busy      = !idle;
    assign status.init_step = step_reg;

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        byte_next  = byte_reg;
        step_next  = step_reg;
        rs_next    = rs_reg;
        en_next    = en_reg;
        nib_next   = nib_reg;
        advance    = 1'b0;
        rej        = 1'b0;

        if (fire)
        begin
            case (op.kind)
                K_TICK:
                begin
                    if (!idle)
                    begin
                        if (wait_reg > 16'd1)
                        begin
                            wait_next = wait_reg - 16'd1;
                        end
                        else
                        begin
                            wait_next = 16'd0;
                            advance   = 1'b1;
                        end
                    end
                end
                K_BYTE:
                begin
                    if (!idle)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        step_next  = STEP_NONE;
                        byte_next  = op.byte_value;
                        rs_next    = op.select;
                        phase_next = PH_BSETUP;
                        wait_next  = {8'd0, cfg.setup_ticks};
                    end
                end
                K_INIT:
                begin
                    if (!idle)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        step_next  = STEP_WAKE_FIRST;
                        phase_next = PH_POWER;
                        wait_next  = cfg.power_up_ticks;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (advance)
        begin
            case (phase_reg)
                PH_POWER:
                begin
                    rs_next    = 1'b0;
                    phase_next = PH_WSETUP;
                    wait_next  = {8'd0, cfg.setup_ticks};
                end
                PH_WSETUP:
                begin
                    en_next    = 1'b1;
                    phase_next = PH_WLEAD;
                    wait_next  = {8'd0, cfg.enable_lead_ticks};
                end
                PH_WLEAD:
                begin
                    nib_next   = (step_reg == STEP_WAKE_LAST) ? NIB_4BIT : NIB_WAKE;
                    phase_next = PH_WHOLD;
                    wait_next  = {8'd0, cfg.enable_hold_ticks};
                end
                PH_WHOLD:
                begin
                    en_next = 1'b0;
                    if (step_reg == STEP_WAKE_FIRST)
                    begin
                        phase_next = PH_WAFTER;
                        wait_next  = cfg.wake_long_ticks;
                    end
                    else if (step_reg == 4'd2 || step_reg == 4'd3)
                    begin
                        phase_next = PH_WAFTER;
                        wait_next  = cfg.wake_short_ticks;
                    end
                    else
                    begin
                        step_next  = STEP_CMD_FIRST;
                        byte_next  = init_cmd(2'd0);
                        rs_next    = 1'b0;
                        phase_next = PH_BSETUP;
                        wait_next  = {8'd0, cfg.setup_ticks};
                    end
                end
                PH_WAFTER:
                begin
                    step_next  = step_reg + 4'd1;
                    rs_next    = 1'b0;
                    phase_next = PH_WSETUP;
                    wait_next  = {8'd0, cfg.setup_ticks};
                end
                PH_BSETUP:
                begin
                    en_next    = 1'b1;
                    phase_next = PH_BLEAD1;
                    wait_next  = {8'd0, cfg.enable_lead_ticks};
                end
                PH_BLEAD1:
                begin
                    nib_next   = byte_reg[7:4];
                    phase_next = PH_BHOLD1;
                    wait_next  = {8'd0, cfg.enable_hold_ticks};
                end
                PH_BHOLD1:
                begin
                    en_next    = 1'b0;
                    phase_next = PH_BGAP;
                    wait_next  = {8'd0, cfg.nibble_gap_ticks};
                end
                PH_BGAP:
                begin
                    en_next    = 1'b1;
                    phase_next = PH_BLEAD2;
                    wait_next  = {8'd0, cfg.enable_lead_ticks};
                end
                PH_BLEAD2:
                begin
                    nib_next   = byte_reg[3:0];
                    phase_next = PH_BHOLD2;
                    wait_next  = {8'd0, cfg.enable_hold_ticks};
                end
                PH_BHOLD2:
                begin
                    en_next = 1'b0;
                    if (step_reg >= STEP_CMD_FIRST)
                    begin
                        phase_next = PH_SETTLE;
                        wait_next  = cfg.settle_ticks;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = 16'd0;
                        step_next  = STEP_NONE;
                    end
                end
                PH_SETTLE:
                begin
                    if (step_reg >= STEP_CMD_FIRST && step_reg < STEP_CMD_LAST)
                    begin
                        // next init byte: index is the low two bits of the old step
                        step_next  = step_reg + 4'd1;
                        byte_next  = init_cmd(step_reg[1:0]);
                        rs_next    = 1'b0;
                        phase_next = PH_BSETUP;
                        wait_next  = {8'd0, cfg.setup_ticks};
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = 16'd0;
                        step_next  = STEP_NONE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    wait_next  = 16'd0;
                    step_next  = STEP_NONE;
                end
            endcase
        end

        res.reg_select  = rs_next;
        res.read_write  = 1'b0;
        res.enable_pin  = en_next;
        res.data_nibble = nib_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.rejected    = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= 16'd0;
            byte_reg  <= 8'd0;
            step_reg  <= STEP_NONE;
            rs_reg    <= 1'b0;
            en_reg    <= 1'b0;
            nib_reg   <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            byte_reg  <= byte_next;
            step_reg  <= step_next;
            rs_reg    <= rs_next;
            en_reg    <= en_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

[dv/tb_char_lcd_nibble_write_sequencer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer_core: self-checking bench for the lcd sequencer
// streams ticks and byte / init / goto requests into the request queue, keeps
// its own model of the rs / e / d4..d7 levels and checks every popped result
// against it; timing registers are reloaded between phases, zero and top included
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer_core;
    import lcdnw_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    // results trail requests through both queues plus two buffered slots
    localparam int QUIET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    // watchdog limit on the whole run
    localparam int CYCLE_LIMIT  = 40000;
    localparam int PHASE_ITEMS  = 40;

    // opcodes the block has no use for
    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_RSVD_C = 3'd7;

    // ticks on a run-to-idle row
    localparam logic [15:0] RUN_TO_IDLE = 16'd0;

    localparam logic [7:0] GOTO_BASE   = 8'h80;
    localparam logic [7:0] ROW1_OFFSET = 8'h40;

    // command bytes after the wake nibbles, entry 0 goes first
    localparam logic [3:0][7:0] INIT_BYTES  = {8'h02, 8'h01, 8'h0C, 8'h2C};
    localparam logic [3:0][2:0] START_CODES = {CMD_INIT, CMD_GOTO, CMD_DATAB, CMD_CMDB};

    localparam result_t NO_WANT = '0;

    // short waits for the directed power-up sequence
    localparam cfg_t INIT_TIMING = '{
        setup_ticks:       8'd2,
        enable_lead_ticks: 8'd1,
        enable_hold_ticks: 8'd2,
        nibble_gap_ticks:  8'd3,
        power_up_ticks:    16'd40,
        wake_long_ticks:   16'd20,
        wake_short_ticks:  16'd5,
        settle_ticks:      16'd10
    };

    typedef struct packed {
        request_t    req;
        logic [15:0] reps;
        logic        typed;
        result_t     want;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    request_t              request   = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    char_lcd_nibble_write_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // model state: timing copy, sequencer phase, counters and pin levels
    // ------------------------------------------------------------------------
    cfg_t        timing;
    phase_t      seq_phase    = PH_IDLE;
    logic [15:0] ticks_left   = '0;
    logic [7:0]  latched_byte = '0;
    logic        latched_sel  = 1'b0;
    logic [3:0]  init_pos     = STEP_NONE;
    logic        pin_rs       = 1'b0;
    logic        pin_e        = 1'b0;
    logic [3:0]  pin_nib      = '0;

    // pin levels owed by the block, oldest first
    result_t     pin_levels_due [$];
    stim_row_t   dir_rows [$];

    int          err_count   = 0;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    logic [15:0] pop_pattern = '1;
    logic [31:0] pop_slot    = '0;

    // power-on timing, kept apart from the package constant on purpose
    initial
    begin
        timing.setup_ticks       = 8'd10;
        timing.enable_lead_ticks = 8'd5;
        timing.enable_hold_ticks = 8'd10;
        timing.nibble_gap_ticks  = 8'd20;
        timing.power_up_ticks    = 16'd20000;
        timing.wake_long_ticks   = 16'd10000;
        timing.wake_short_ticks  = 16'd1000;
        timing.settle_ticks      = 16'd5000;
    end

    task automatic enter_phase(input phase_t p, input logic [15:0] n);
        seq_phase  = p;
        ticks_left = n;
    endtask

    task automatic start_byte(input logic [7:0] value, input logic sel);
        latched_byte = value;
        latched_sel  = sel;
        pin_rs       = sel;
        enter_phase(PH_BSETUP, {8'h00, timing.setup_ticks});
    endtask

    // wake nibbles always go out as commands
    task automatic start_wake();
        pin_rs = 1'b0;
        enter_phase(PH_WSETUP, {8'h00, timing.setup_ticks});
    endtask

    task automatic go_idle();
        seq_phase  = PH_IDLE;
        ticks_left = '0;
        init_pos   = STEP_NONE;
    endtask

    // action taken when the current timed phase runs out
    task automatic advance_phase();
        case (seq_phase)
            PH_POWER:  start_wake();
            PH_WSETUP:
            begin
                pin_e = 1'b1;
                enter_phase(PH_WLEAD, {8'h00, timing.enable_lead_ticks});
            end
            PH_WLEAD:
            begin
                // the last wake nibble switches the panel to 4-bit mode
                pin_nib = (init_pos == STEP_WAKE_LAST) ? NIB_4BIT : NIB_WAKE;
                enter_phase(PH_WHOLD, {8'h00, timing.enable_hold_ticks});
            end
            PH_WHOLD:
            begin
                pin_e = 1'b0;
                if (init_pos == STEP_WAKE_FIRST)
                    enter_phase(PH_WAFTER, timing.wake_long_ticks);
                else if (init_pos > STEP_WAKE_FIRST && init_pos < STEP_WAKE_LAST)
                    enter_phase(PH_WAFTER, timing.wake_short_ticks);
                else
                begin
                    init_pos = STEP_CMD_FIRST;
                    start_byte(INIT_BYTES[0], 1'b0);
                end
            end
            PH_WAFTER:
            begin
                init_pos = init_pos + 4'd1;
                start_wake();
            end
            PH_BSETUP:
            begin
                pin_e = 1'b1;
                enter_phase(PH_BLEAD1, {8'h00, timing.enable_lead_ticks});
            end
            PH_BLEAD1:
            begin
                pin_nib = latched_byte[7:4];
                enter_phase(PH_BHOLD1, {8'h00, timing.enable_hold_ticks});
            end
            PH_BHOLD1:
            begin
                pin_e = 1'b0;
                enter_phase(PH_BGAP, {8'h00, timing.nibble_gap_ticks});
            end
            PH_BGAP:
            begin
                pin_e = 1'b1;
                enter_phase(PH_BLEAD2, {8'h00, timing.enable_lead_ticks});
            end
            PH_BLEAD2:
            begin
                pin_nib = latched_byte[3:0];
                enter_phase(PH_BHOLD2, {8'h00, timing.enable_hold_ticks});
            end
            PH_BHOLD2:
            begin
                pin_e = 1'b0;
                if (init_pos >= STEP_CMD_FIRST)
                    enter_phase(PH_SETTLE, timing.settle_ticks);
                else
                    go_idle();
            end
            PH_SETTLE:
            begin
                if (init_pos >= STEP_CMD_FIRST && init_pos < STEP_CMD_LAST)
                begin
                    init_pos = init_pos + 4'd1;
                    start_byte(INIT_BYTES[2'(init_pos - STEP_CMD_FIRST)], 1'b0);
                end
                else
                    go_idle();
            end
            default:   go_idle();
        endcase
    endtask

    // pin levels after one transaction, model state moves along
    task automatic next_pin_levels(input request_t r, output result_t o);
        logic rej;
        rej = 1'b0;
        case (r.cmd)
            CMD_TICK:
            begin
                if (seq_phase != PH_IDLE)
                begin
                    if (ticks_left > 16'd1)
                        ticks_left = ticks_left - 16'd1;
                    else
                    begin
                        // zero wait still costs one tick
                        ticks_left = '0;
                        advance_phase();
                    end
                end
            end
            CMD_CMDB, CMD_DATAB, CMD_INIT, CMD_GOTO:
            begin
                if (seq_phase != PH_IDLE)
                    rej = 1'b1;
                else if (r.cmd == CMD_CMDB)
                begin
                    init_pos = STEP_NONE;
                    start_byte(r.byte_value, 1'b0);
                end
                else if (r.cmd == CMD_DATAB)
                begin
                    init_pos = STEP_NONE;
                    start_byte(r.byte_value, 1'b1);
                end
                else if (r.cmd == CMD_INIT)
                begin
                    init_pos = STEP_WAKE_FIRST;
                    enter_phase(PH_POWER, timing.power_up_ticks);
                end
                else
                begin
                    // address byte: base plus column plus row offset
                    init_pos = STEP_NONE;
                    start_byte(GOTO_BASE + {2'b00, r.column} + (r.row ? ROW1_OFFSET : 8'h00),
                               1'b0);
                end
            end
            default: ;
        endcase
        o.reg_select  = pin_rs;
        o.read_write  = 1'b0;
        o.enable_pin  = pin_e;
        o.data_nibble = pin_nib;
        o.busy_res    = (seq_phase != PH_IDLE);
        o.rejected    = rej;
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_pins(input result_t got, input result_t want);
        if (got.reg_select !== want.reg_select)
            report_mismatch("reg_select", 8'(got.reg_select), 8'(want.reg_select));
        if (got.read_write !== want.read_write)
            report_mismatch("read_write", 8'(got.read_write), 8'(want.read_write));
        if (got.enable_pin !== want.enable_pin)
            report_mismatch("enable_pin", 8'(got.enable_pin), 8'(want.enable_pin));
        if (got.data_nibble !== want.data_nibble)
            report_mismatch("data_nibble", 8'(got.data_nibble), 8'(want.data_nibble));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        if (got.rejected !== want.rejected)
            report_mismatch("rejected", 8'(got.rejected), 8'(want.rejected));
    endtask

    // result side: pop follows a 16-slot pattern, redrawn whenever the low six
    // slot bits wrap; every fourth slot always pops so the stall stays bounded
    always @(negedge clk)
    begin
        if (pop_slot[5:0] == 6'd0)
            pop_pattern = ($urandom_range(0, 9) < 3) ? 16'hFFFF
                                                     : (16'($urandom) | 16'h8888);
        pop <= pop_pattern[pop_slot[3:0]];
        pop_slot = pop_slot + 32'd1;
    end

    // a result transaction completes on pop with empty low
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pin_levels_due.size() == 0)
                report_mismatch("result with nothing expected", 8'd1, 8'd0);
            else
                check_pins(result, pin_levels_due.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic result_t pin_word(input logic rs, input logic e, input logic [3:0] nib,
                                         input logic busy, input logic rej);
        result_t w;
        w.reg_select  = rs;
        w.read_write  = 1'b0;
        w.enable_pin  = e;
        w.data_nibble = nib;
        w.busy_res    = busy;
        w.rejected    = rej;
        return w;
    endfunction

    function automatic request_t random_request(input logic [2:0] code);
        request_t r;
        r.cmd        = code;
        r.byte_value = 8'($urandom_range(0, 255));
        r.row        = 1'($urandom_range(0, 1));
        r.column     = 6'($urandom_range(0, 63));
        return r;
    endfunction

    function automatic cfg_t random_timing(input int max8, input int max16);
        cfg_t c;
        c.setup_ticks       = 8'($urandom_range(0, max8));
        c.enable_lead_ticks = 8'($urandom_range(0, max8));
        c.enable_hold_ticks = 8'($urandom_range(0, max8));
        c.nibble_gap_ticks  = 8'($urandom_range(0, max8));
        c.power_up_ticks    = 16'($urandom_range(0, max16));
        c.wake_long_ticks   = 16'($urandom_range(0, max16));
        c.wake_short_ticks  = 16'($urandom_range(0, max16));
        c.settle_ticks      = 16'($urandom_range(0, max16));
        return c;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [7:0] b, input logic rw,
                           input logic [5:0] col, input logic [15:0] reps,
                           input logic typed, input result_t want);
        stim_row_t s;
        s.req.cmd        = cmd;
        s.req.byte_value = b;
        s.req.row        = rw;
        s.req.column     = col;
        s.reps           = reps;
        s.typed          = typed;
        s.want           = want;
        dir_rows.push_back(s);
    endtask

    // one request transaction; the sender runs in bursts with short gaps,
    // now and then a burst is long enough to cover a whole sequence
    task automatic send_item(input request_t r, input logic typed, input result_t want);
        result_t predicted;
        int      gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            push = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 2000)
                                                     : $urandom_range(4, 40);
        end
        burst_left--;
        @(negedge clk);
        push    = 1'b1;
        request = r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // accepted at this edge
        next_pin_levels(r, predicted);
        pin_levels_due.push_back(typed ? want : predicted);
    endtask

    task automatic tick_until_idle();
        while (seq_phase != PH_IDLE)
            send_item(random_request(CMD_TICK), 1'b0, NO_WANT);
    endtask

    // walk the stimulus table, then clear it for the next one
    task automatic run_rows();
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].req.cmd == CMD_TICK && dir_rows[k].reps == RUN_TO_IDLE)
                tick_until_idle();
            else
                repeat (dir_rows[k].reps)
                    send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        end
        dir_rows.delete();
    endtask

    // registers only change with the block idle and every result drained
    task automatic load_timing(input cfg_t c);
        logic [31:0] junk;
        logic [2:0]  idx;
        @(negedge clk);
        push = 1'b0;
        while (pin_levels_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            junk = $urandom;
            idx  = 3'(i);
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            // upper byte of the 8-bit registers carries junk that must be dropped
            case (idx)
                REG_SETUP:      cfg_data = {junk[7:0], c.setup_ticks};
                REG_LEAD:       cfg_data = {junk[7:0], c.enable_lead_ticks};
                REG_HOLD:       cfg_data = {junk[7:0], c.enable_hold_ticks};
                REG_GAP:        cfg_data = {junk[7:0], c.nibble_gap_ticks};
                REG_POWER_UP:   cfg_data = c.power_up_ticks;
                REG_WAKE_LONG:  cfg_data = c.wake_long_ticks;
                REG_WAKE_SHORT: cfg_data = c.wake_short_ticks;
                default:        cfg_data = c.settle_ticks;
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        timing    = c;
    endtask

    // mostly well-formed: a request when idle then ticks until done, with
    // idle ticks, unused opcodes and requests that collide with a busy block
    task automatic run_random(input int n_items);
        logic [2:0] code;
        logic       idle;
        int         roll;
        int         counted;
        counted = 0;
        while (counted < n_items)
        begin
            idle = (seq_phase == PH_IDLE);
            roll = $urandom_range(0, 99);
            if (idle)
            begin
                if (roll < 8)
                    code = CMD_TICK;
                else if (roll < 14)
                    code = CMD_RSVD_A + 3'($urandom_range(0, 2));
                else if (roll < 20)
                    code = CMD_INIT;
                else
                    code = START_CODES[2'($urandom_range(0, 2))];
            end
            else
            begin
                if (roll < 90)
                    code = CMD_TICK;
                else if (roll < 97)
                    code = START_CODES[2'($urandom_range(0, 3))];
                else
                    code = CMD_RSVD_A + 3'($urandom_range(0, 2));
            end
            send_item(random_request(code), 1'b0, NO_WANT);
            // idle ticks and unused opcodes do nothing, leave them out
            if (code < CMD_RSVD_A && !(idle && code == CMD_TICK))
                counted++;
        end
        tick_until_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t extreme;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at power-on timing
        // idle tick right out of reset, nothing moves
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'h0, 1'b0, 1'b0));
        // unused opcodes on an idle block are ignored
        add_row(CMD_RSVD_A, 8'hFF, 1'b1, 6'h3F, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'h0, 1'b0, 1'b0));
        add_row(CMD_RSVD_B, 8'hFF, 1'b1, 6'h3F, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'h0, 1'b0, 1'b0));
        add_row(CMD_RSVD_C, 8'hFF, 1'b1, 6'h3F, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'h0, 1'b0, 1'b0));
        // data byte: select rises at once, nibble stays at its old value
        add_row(CMD_DATAB,  8'hFF, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b1, 1'b0, 4'h0, 1'b1, 1'b0));
        // requests on a busy block are dropped
        add_row(CMD_CMDB,   8'h00, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b1, 1'b0, 4'h0, 1'b1, 1'b1));
        add_row(CMD_INIT,   8'h00, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b1, 1'b0, 4'h0, 1'b1, 1'b1));
        // past the setup wait, then collisions while enable is high
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, 16'd12, 1'b0, NO_WANT);
        add_row(CMD_GOTO,   8'h00, 1'b1, 6'h3F, 16'd1, 1'b0, NO_WANT);
        add_row(CMD_RSVD_B, 8'h00, 1'b0, 6'h00, 16'd1, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, RUN_TO_IDLE, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b1, 1'b0, 4'hF, 1'b0, 1'b0));
        // all-zero command byte
        add_row(CMD_CMDB,   8'h00, 1'b0, 6'h00, 16'd1, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, RUN_TO_IDLE, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'hFF, 1'b1, 6'h3F, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'h0, 1'b0, 1'b0));
        // goto corner, row one at the last column gives address 0xFF
        add_row(CMD_GOTO,   8'h00, 1'b1, 6'h3F, 16'd1, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, RUN_TO_IDLE, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'hF, 1'b0, 1'b0));
        run_rows();

        // full power-up sequence at short waits, a data byte collides early
        load_timing(INIT_TIMING);
        add_row(CMD_INIT,   8'h00, 1'b0, 6'h00, 16'd1, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, 16'd30, 1'b0, NO_WANT);
        add_row(CMD_DATAB,  8'h33, 1'b0, 6'h00, 16'd1, 1'b0, NO_WANT);
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, RUN_TO_IDLE, 1'b0, NO_WANT);
        // init ends on the low nibble of its last command byte
        add_row(CMD_TICK,   8'h00, 1'b0, 6'h00, 16'd1, 1'b1,
                pin_word(1'b0, 1'b0, 4'h2, 1'b0, 1'b0));
        run_rows();

        // every wait at zero still costs one tick per phase
        load_timing('0);
        run_random(PHASE_ITEMS);

        repeat (2)
        begin
            load_timing(random_timing(3, 5));
            run_random(PHASE_ITEMS);
        end

        load_timing(random_timing(12, 20));
        run_random(PHASE_ITEMS);

        // top of the 8-bit range on the setup wait, every other wait at zero
        extreme.setup_ticks       = 8'hFF;
        extreme.enable_lead_ticks = 8'h00;
        extreme.enable_hold_ticks = 8'h00;
        extreme.nibble_gap_ticks  = 8'h00;
        extreme.power_up_ticks    = 16'h0000;
        extreme.wake_long_ticks   = 16'h0000;
        extreme.wake_short_ticks  = 16'h0000;
        extreme.settle_ticks      = 16'h0000;
        load_timing(extreme);
        send_item(random_request(CMD_DATAB), 1'b0, NO_WANT);
        tick_until_idle();

        // drain, then idle for DRAIN_CYCLES to give the block room to misbehave
        @(negedge clk);
        push = 1'b0;
        while (pin_levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
